// ===== rtl/core/led_chase_pattern_generator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LED chase pattern generator
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LED_CHASE_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define LED_CHASE_PATTERN_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// check that cond holds at every edge out of reset
`define LCPG_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lcpg assertion failed");
// check that cons holds in the same cycle as ante
`define LCPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcpg implication failed");
// check that cons holds in the cycle after ante
`define LCPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcpg next-cycle check failed");
`else
`define LCPG_ASSERT(lbl, clk, rst_n, cond)
`define LCPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/lcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpg_pkg
// Shared types and constants of the LED chase pattern generator.
// ----------------------------------------------------------------------------
package lcpg_pkg;

    localparam int POS_W              = 9;   // signed spot position
    localparam int DEF_SPOT_COUNT     = 10;
    localparam int DEF_SPOT_SPACING   = 3;

    localparam logic [7:0]       SEG_LEN_RESET = 8'd60;
    localparam logic [7:0]       DIM_LEVEL     = 8'd10;
    localparam logic [POS_W-1:0] WRAP_POS      = 9'h1FD;  // minus three

    typedef enum logic [2:0] {
        REG_SEG_LEN  = 3'd0,
        REG_REVERSE  = 3'd1,
        REG_BACKWARD = 3'd2,
        REG_RED      = 3'd3,
        REG_GREEN    = 3'd4,
        REG_BLUE     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] seg_len;
        logic       reverse;
        logic       backward;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/core/lcpg_regs.sv =====
// ----------------------------------------------------------------------------
// lcpg_regs
// APB-style configuration registers, one per 32-bit word.
// ----------------------------------------------------------------------------
module lcpg_regs import lcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_len  <= SEG_LEN_RESET;
            r_cfg.reverse  <= 1'b0;
            r_cfg.backward <= 1'b0;
            r_cfg.red      <= 8'd0;
            r_cfg.green    <= 8'd0;
            r_cfg.blue     <= 8'd0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SEG_LEN:  r_cfg.seg_len  <= pwdata[7:0];
                REG_REVERSE:  r_cfg.reverse  <= pwdata[0];
                REG_BACKWARD: r_cfg.backward <= pwdata[0];
                REG_RED:      r_cfg.red      <= pwdata[7:0];
                REG_GREEN:    r_cfg.green    <= pwdata[7:0];
                REG_BLUE:     r_cfg.blue     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (w_idx)
            REG_SEG_LEN:  prdata = {24'd0, r_cfg.seg_len};
            REG_REVERSE:  prdata = {31'd0, r_cfg.reverse};
            REG_BACKWARD: prdata = {31'd0, r_cfg.backward};
            REG_RED:      prdata = {24'd0, r_cfg.red};
            REG_GREEN:    prdata = {24'd0, r_cfg.green};
            REG_BLUE:     prdata = {24'd0, r_cfg.blue};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/lcpg_cell.sv =====
// ----------------------------------------------------------------------------
// lcpg_cell
// One spot of the rotating position ring.
// ----------------------------------------------------------------------------
module lcpg_cell import lcpg_pkg::*; #(
    parameter logic [POS_W-1:0] INIT_POS = '0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_shift,
    input  logic [POS_W-1:0] i_shift_in,
    input  logic [7:0]       i_seg_len,
    output logic [POS_W-1:0] o_pos,
    output logic             o_will_write
);

    logic [POS_W-1:0] r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= INIT_POS;
        end else if (i_load) begin
            r_pos <= INIT_POS;
        end else if (i_shift) begin
            r_pos <= i_shift_in;
        end
    end

    assign o_pos = r_pos;

    // a spot writes if it is past zero, or at zero in a non-empty segment
    assign o_will_write = ($signed(r_pos) > 0) ||
                          ((r_pos == '0) && (i_seg_len != 8'd0));

endmodule

// ===== rtl/core/led_chase_pattern_generator_top.sv =====
// ----------------------------------------------------------------------------
// led_chase_pattern_generator_top
// Chase animation: a ring of spot cells rotates past one head evaluator.
// ----------------------------------------------------------------------------
// One input transfer is one animation tick. The tick is worked off by
// rotating the ring of SPOT_COUNT position cells past a single evaluator at
// its head: each spot first emits the dim pixel it leaves behind, if any, then
// its color pixel where that falls in the segment, and the ring holds while
// the output side stalls. Each cycle yields at most one pixel write through
// the output register; the final write of a tick carries last_write. o_stall
// is high while a tick is in progress, and the next tick is taken on the
// cycle after its last spot.
`include "led_chase_pattern_generator_top_assert.svh"

module led_chase_pattern_generator_top import lcpg_pkg::*; #(
    parameter int SPOT_COUNT   = DEF_SPOT_COUNT,
    parameter int SPOT_SPACING = DEF_SPOT_SPACING
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last_write
);

    localparam int CNT_W = $clog2(SPOT_COUNT + 1);

    t_cfg w_cfg;

    lcpg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ring of spot cells
    logic [POS_W-1:0] w_pos      [SPOT_COUNT];
    logic [POS_W-1:0] w_shift_in [SPOT_COUNT];
    logic             w_will     [SPOT_COUNT];
    logic [POS_W-1:0] w_tail;
    logic             w_load;
    logic             w_shift;

    for (genvar k = 0; k < SPOT_COUNT; k++) begin : g_cell
        localparam logic [POS_W-1:0] INIT_K = POS_W'(-(k * SPOT_SPACING));
        if (k == SPOT_COUNT - 1) begin : g_tail
            assign w_shift_in[k] = w_tail;
        end else begin : g_link
            assign w_shift_in[k] = w_pos[k+1];
        end
        lcpg_cell #(.INIT_POS(INIT_K)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_load),
            .i_shift      (w_shift),
            .i_shift_in   (w_shift_in[k]),
            .i_seg_len    (w_cfg.seg_len),
            .o_pos        (w_pos[k]),
            .o_will_write (w_will[k])
        );
    end

    // sequencer state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_remaining, n_remaining;
    logic             r_phase, n_phase;
    logic             r_needs_init;
    logic             r_out_valid;
    logic [7:0]       r_pixel_index, r_red, r_green, r_blue;
    logic             r_last_write;

    logic             w_accept;
    logic             w_out_free;
    logic             w_step;
    logic             w_dim_ok;
    logic             w_color_ok;
    logic             w_color_follows;
    logic             w_any_later;
    logic [POS_W-1:0] w_head;
    logic [POS_W-1:0] w_pw;
    logic [8:0]       w_len9;
    logic             w_emit;
    logic [7:0]       w_idx;
    logic [7:0]       w_idx_fin;
    logic [7:0]       w_red, w_green, w_blue;
    logic             w_last;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = (r_state == ST_RUN) && w_out_free;
    assign w_head     = w_pos[0];
    assign w_len9     = {1'b0, w_cfg.seg_len};
    assign w_dim_ok   = !r_phase && ($signed(w_head) > 0);
    assign w_pw       = ($signed(w_head) >= $signed(w_len9)) ? WRAP_POS : w_head;
    assign w_color_ok = !w_pw[POS_W-1];
    assign w_color_follows = $signed(w_head) < $signed(w_len9);
    assign w_tail     = w_pw + POS_W'(1);

    // writes still due from spots behind the head in this tick
    always_comb begin
        w_any_later = 1'b0;
        for (int k = 1; k < SPOT_COUNT; k++) begin
            if (CNT_W'(k) < r_remaining) begin
                w_any_later = w_any_later | w_will[k];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_out_free && !w_dim_ok && (r_remaining == CNT_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall     = 1'b1;
        w_load      = 1'b0;
        w_shift     = 1'b0;
        w_emit      = 1'b0;
        w_last      = 1'b0;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                w_load  = w_accept && (i_restart || r_needs_init);
                if (w_accept) begin
                    n_remaining = CNT_W'(SPOT_COUNT);
                    n_phase     = 1'b0;
                end
            end
            ST_RUN: begin
                if (w_step) begin
                    if (w_dim_ok) begin
                        // dim pixel first, then the color pixel of the same spot
                        w_emit  = 1'b1;
                        w_last  = !w_color_follows && !w_any_later;
                        n_phase = 1'b1;
                    end else begin
                        w_emit      = w_color_ok;
                        w_last      = !w_any_later;
                        w_shift     = 1'b1;
                        n_phase     = 1'b0;
                        n_remaining = r_remaining - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // pixel index and color of the write at the head
    always_comb begin
        if (w_dim_ok) begin
            w_idx   = w_cfg.backward ? (w_cfg.seg_len - w_head[7:0])
                                     : (w_head[7:0] - 8'd1);
            w_red   = DIM_LEVEL;
            w_green = DIM_LEVEL;
            w_blue  = DIM_LEVEL;
        end else begin
            w_idx   = w_cfg.backward ? (w_cfg.seg_len - 8'd1 - w_pw[7:0])
                                     : w_pw[7:0];
            w_red   = w_cfg.red;
            w_green = w_cfg.green;
            w_blue  = w_cfg.blue;
        end
        w_idx_fin = w_cfg.reverse ? (w_cfg.seg_len - 8'd1 - w_idx) : w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_remaining  <= '0;
            r_phase      <= 1'b0;
            r_needs_init <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_phase     <= n_phase;
            if (w_accept) r_needs_init <= 1'b0;
            if (w_out_free) r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_pixel_index <= w_idx_fin;
            r_red         <= w_red;
            r_green       <= w_green;
            r_blue        <= w_blue;
            r_last_write  <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_pixel_index;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_last_write  = r_last_write;

    `LCPG_ASSERT_NXT(a_tick_start, i_clk, i_rst_n, w_accept,
        (r_state == ST_RUN) && (r_remaining == CNT_W'(SPOT_COUNT)))
    `LCPG_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_stall,
        !w_shift && !w_emit)
    `LCPG_ASSERT_IMP(a_phase_head, i_clk, i_rst_n, r_phase,
        (r_state == ST_RUN) && ($signed(w_head) > 0))

endmodule
